FILE: rtl/horner_polynomial_evaluator_assert.svh
// Assertion macros for the Horner polynomial evaluator.
// Each macro samples on clock and is disabled while reset is high.
`ifndef HORNER_POLYNOMIAL_EVALUATOR_ASSERT_SVH
`define HORNER_POLYNOMIAL_EVALUATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/hpe_pkg.sv
// Shared widths, codes and types for the Horner polynomial evaluator.
// No dependencies; used by hpe_mac and horner_polynomial_evaluator.
package hpe_pkg;

   localparam int COEF_W     = 16;
   localparam int X_W        = 16;
   localparam int VAL_W      = 48;
   localparam int TERM_W     = 5;
   localparam int INDEX_W    = 4;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_EVAL  = 1'b1;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [X_W-1:0]    x_type;
   typedef logic signed [VAL_W-1:0]  acc_type;

   typedef struct packed {
      logic    sat;
      acc_type value;
   } mac_result_type;

   localparam acc_type VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam acc_type VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

FILE: rtl/horner_polynomial_evaluator.sv
// Horner polynomial evaluator top level: coefficient memory, sequencer and
// output register. Depends on hpe_pkg, hpe_mac and the assertion header.
//
//   Channel  Direction  Beat carries
//   req_     in         tuser action; tdata coef_index, coef_value, x_point
//   rsp_     out        tdata poly_value; tuser overflow, empty_res
//   csr_     in         term_count write, no read-back
//
// An evaluation over n effective terms steps through the shared
// multiply-accumulate unit, highest coefficient first; an empty polynomial
// goes straight to the finish state. The coefficient memory read is
// registered. Reset is synchronous and clears the term count, the sequencer
// state and the result valid flag. A finished result waits in the output
// register, and coefficient writes are still taken while it waits.
module horner_polynomial_evaluator #(
   parameter int MAX_TERMS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [3:0] coef_index, [19:4] coef_value, [35:20] x_point, [39:36] unused.
   input  logic [hpe_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] action.
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [47:0] poly_value.
   output logic [hpe_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] overflow, [1] empty_res.
   output logic [hpe_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  logic                            csr_wr_en,
   input  logic [hpe_pkg::TERM_W-1:0]      csr_wr_data
);
   import hpe_pkg::*;

   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CW = $clog2(MAX_TERMS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [INDEX_W-1:0]    coef_index;
   coef_type              coef_value;
   x_type                 x_point;
   logic                  req_beat;

   logic [TERM_W-1:0]     term_count_ff;
   logic [CW-1:0]         n_eff;

   logic [2:0]            state_ff, state_in;
   logic [AW-1:0]         j_ff, j_in;
   acc_type               acc_ff, acc_in;
   x_type                 x_ff, x_in;
   logic                  ovf_ff, ovf_in;
   logic                  empty_ff, empty_in;

   coef_type              coef_mem [MAX_TERMS];
   coef_type              rd_data_ff;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;

   logic                  mul_en;
   mac_result_type        mac_result;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   acc_type               rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;
   logic                  load_out;
   logic                  out_free;

   assign coef_index = req_tdata[INDEX_W-1:0];
   assign coef_value = req_tdata[INDEX_W+COEF_W-1:INDEX_W];
   assign x_point    = req_tdata[INDEX_W+COEF_W+X_W-1:INDEX_W+COEF_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;

   assign n_eff = (32'(term_count_ff) > MAX_TERMS) ? CW'(MAX_TERMS) : CW'(term_count_ff);

   assign wr_en   = req_beat && (req_tuser == ACTION_WRITE) && (32'(coef_index) < MAX_TERMS);
   assign wr_addr = AW'(coef_index);

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      ovf_in   = ovf_ff;
      empty_in = empty_ff;
      rd_en    = 1'b0;
      rd_addr  = j_ff;
      mul_en   = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req_tuser == ACTION_EVAL)) begin
               x_in   = x_point;
               ovf_in = 1'b0;
               if (n_eff == '0) begin
                  acc_in   = '0;
                  empty_in = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  empty_in = 1'b0;
                  j_in     = AW'(n_eff - 1'b1);
                  rd_en    = 1'b1;
                  rd_addr  = AW'(n_eff - 1'b1);
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            acc_in = {{(VAL_W-COEF_W-8){rd_data_ff[COEF_W-1]}}, rd_data_ff, 8'b0};
            if (j_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               j_in     = j_ff - 1'b1;
               rd_en    = 1'b1;
               rd_addr  = j_ff - 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_en   = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            acc_in = mac_result.value;
            ovf_in = ovf_ff || mac_result.sat;
            if (j_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               j_in     = j_ff - 1'b1;
               rd_en    = 1'b1;
               rd_addr  = j_ff - 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (load_out) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         term_count_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            term_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      j_ff     <= j_in;
      acc_ff   <= acc_in;
      x_ff     <= x_in;
      ovf_ff   <= ovf_in;
      empty_ff <= empty_in;
      if (load_out) begin
         rsp_data_ff <= acc_ff;
         rsp_user_ff <= {empty_ff, ovf_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_mem[wr_addr] <= coef_value;
      end
      if (rd_en) begin
         rd_data_ff <= coef_mem[rd_addr];
      end
   end

   hpe_mac u_mac (
      .clock  (clock),
      .mul_en (mul_en),
      .acc    (acc_ff),
      .x      (x_ff),
      .coef   (rd_data_ff),
      .result (mac_result)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `include "horner_polynomial_evaluator_assert.svh"

   `HPE_ASSERT_SAME(a_empty_is_zero, rsp_tvalid_ff && rsp_user_ff[1], (rsp_data_ff == '0) && !rsp_user_ff[0], "Empty result carries a value or an overflow.")
   `HPE_ASSERT_NEXT(a_eval_starts, req_beat && (req_tuser == ACTION_EVAL) && (n_eff != '0), state_ff == ST_LOAD, "Evaluation did not start a coefficient load.")
   `HPE_ASSERT_SAME(a_mul_follows, state_ff == ST_MUL, ($past(state_ff) == ST_LOAD) || ($past(state_ff) == ST_ADD), "Multiply step without a coefficient read.")
   `HPE_ASSERT_SAME(a_out_from_fin, $rose(rsp_tvalid_ff), $past(state_ff) == ST_FIN, "Result beat raised outside the finish state.")

endmodule

FILE: rtl/hpe_mac.sv
// One Horner step on a shared multiply-accumulate unit: registered partial
// products of acc*x, then floor shift by 8, coefficient add and saturation.
// Depends on hpe_pkg.
module hpe_mac (
   input  logic                    clock,
   input  logic                    mul_en,
   input  hpe_pkg::acc_type        acc,
   input  hpe_pkg::x_type          x,
   input  hpe_pkg::coef_type       coef,
   output hpe_pkg::mac_result_type result
);
   import hpe_pkg::*;

   localparam int HALF_W = VAL_W / 2;
   localparam int LO_W   = HALF_W + 1 + X_W;
   localparam int HI_W   = HALF_W + X_W;
   localparam int PROD_W = VAL_W + X_W;
   localparam int SH_W   = PROD_W - 8;
   localparam int SUM_W  = SH_W + 1;

   logic signed [LO_W-1:0]   pp_lo_in, pp_lo_ff;
   logic signed [HI_W-1:0]   pp_hi_in, pp_hi_ff;
   logic signed [PROD_W-1:0] prod;
   logic signed [SH_W-1:0]   shifted;
   logic signed [SUM_W-1:0]  coef_ext;
   logic signed [SUM_W-1:0]  sum;
   logic                     sum_fits;

   assign pp_lo_in = $signed({1'b0, acc[HALF_W-1:0]}) * x;
   assign pp_hi_in = $signed(acc[VAL_W-1:HALF_W]) * x;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
      end
   end

   always_comb begin
      prod     = (PROD_W'(pp_hi_ff) <<< HALF_W) + PROD_W'(pp_lo_ff);
      shifted  = prod[PROD_W-1:8];
      coef_ext = {{(SUM_W-COEF_W-8){coef[COEF_W-1]}}, coef, 8'b0};
      sum      = $signed({shifted[SH_W-1], shifted}) + coef_ext;
      sum_fits = (sum[SUM_W-1:VAL_W-1] == '0) || (sum[SUM_W-1:VAL_W-1] == '1);
      result.sat = !sum_fits;
      if (sum_fits) begin
         result.value = sum[VAL_W-1:0];
      end else if (sum[SUM_W-1]) begin
         result.value = VAL_MIN;
      end else begin
         result.value = VAL_MAX;
      end
   end

endmodule

FILE: sim/horner_polynomial_evaluator_tb.sv
// Self-checking testbench for horner_polynomial_evaluator: directed table, then random beats.
// Expected values come from the directed table where it gives them, else from a local fixed-point Horner predictor.
// Depends on hpe_pkg and the horner_polynomial_evaluator RTL.
module horner_polynomial_evaluator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hpe_pkg::*;

   localparam int MAX_TERMS    = 16;
   localparam int DRAIN_CYCLES = 2 * MAX_TERMS + 8;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASES       = 14;
   localparam int PHASE_BEATS  = 128;

   typedef struct packed {
      acc_type value;
      logic    overflow;
      logic    empty;
   } poly_result_type;

   typedef struct {
      int              terms;
      logic            action;
      logic [3:0]      index;
      coef_type        coef;
      x_type           x;
      bit              known;
      poly_result_type want;
   } table_row_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_wr_en   = 1'b0;
   logic [TERM_W-1:0]     csr_wr_data = '0;

   coef_type        coef_store [MAX_TERMS];
   int              term_setting  = 0;
   int              applied_terms = -1;
   poly_result_type expected_polys [$];
   table_row_type   directed_rows [$];

   int cycle_count   = 0;
   int errors        = 0;
   int writes_sent   = 0;
   int evals_checked = 0;
   int sat_seen      = 0;
   int empty_seen    = 0;
   int settings_made = 0;

   wire quiet = (cycle_count >= 3000) && (cycle_count < 8000);

   horner_polynomial_evaluator #(.MAX_TERMS(MAX_TERMS)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic poly_result_type evaluate_poly(input x_type x);
      int              n;
      longint          acc;
      longint          sum;
      longint          xw;
      poly_result_type r;
      r = '0;
      n = (term_setting > MAX_TERMS) ? MAX_TERMS : term_setting;
      if (n == 0) begin
         r.empty = 1'b1;
         return r;
      end
      xw  = x;
      acc = longint'(coef_store[n-1]) <<< 8;
      for (int j = n - 2; j >= 0; j--) begin
         sum = ((acc * xw) >>> 8) + (longint'(coef_store[j]) <<< 8);
         if (sum > VAL_MAX) begin
            sum = VAL_MAX;
            r.overflow = 1'b1;
         end else if (sum < VAL_MIN) begin
            sum = VAL_MIN;
            r.overflow = 1'b1;
         end
         acc = sum;
      end
      r.value = acc[VAL_W-1:0];
      return r;
   endfunction

   task automatic table_row(input int terms, input logic action, input logic [3:0] index,
                            input coef_type coef, input x_type x, input bit known,
                            input acc_type want_value, input logic want_ovf,
                            input logic want_empty);
      table_row_type row;
      row.terms  = terms;
      row.action = action;
      row.index  = index;
      row.coef   = coef;
      row.x      = x;
      row.known  = known;
      row.want   = '{value: want_value, overflow: want_ovf, empty: want_empty};
      directed_rows.push_back(row);
   endtask

   task automatic set_terms(input int n);
      req_tvalid <= 1'b0;
      while (expected_polys.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= TERM_W'(n);
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      term_setting  = n;
      applied_terms = n;
      settings_made++;
   endtask

   task automatic send_item(input logic action, input logic [3:0] index, input coef_type coef,
                            input x_type x, input bit known, input poly_result_type want);
      while (!quiet && $urandom_range(0, 99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {4'b0, x, coef, index};
      do @(posedge clock); while (!req_tready);
      if (action == ACTION_WRITE) begin
         coef_store[index] = coef;
         writes_sent++;
      end else if (known) begin
         expected_polys.push_back(want);
      end else begin
         expected_polys.push_back(evaluate_poly(x));
      end
   endtask

   always @(posedge clock) begin
      poly_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_polys.size() == 0) begin
            $display("%0t: result beat with nothing expected, got %0d", $time,
                     $signed(rsp_tdata));
            errors++;
         end else begin
            want = expected_polys.pop_front();
            evals_checked++;
            if (rsp_tdata != want.value) begin
               $display("%0t: poly_value mismatch, expected %0d, actual %0d", $time,
                        want.value, $signed(rsp_tdata));
               errors++;
            end
            if (rsp_tuser[0] != want.overflow) begin
               $display("%0t: overflow mismatch, expected %0b, actual %0b", $time,
                        want.overflow, rsp_tuser[0]);
               errors++;
            end
            if (rsp_tuser[1] != want.empty) begin
               $display("%0t: empty_res mismatch, expected %0b, actual %0b", $time,
                        want.empty, rsp_tuser[1]);
               errors++;
            end
            if (rsp_tuser[0]) sat_seen++;
            if (rsp_tuser[1]) empty_seen++;
         end
      end
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 8);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int              phase_terms [7];
      int              n;
      logic            action;
      coef_type        coef;
      x_type           x;
      poly_result_type none;
      none        = '0;
      phase_terms = '{16, 1, 31, 0, 2, 17, 8};

      table_row(0, ACTION_EVAL, 4'd9, 16'sh1234, 16'sh0000, 1, 48'sd0, 1'b0, 1'b1);
      table_row(0, ACTION_EVAL, 4'd0, 16'sh0000, -16'sd32768, 1, 48'sd0, 1'b0, 1'b1);
      table_row(0, ACTION_WRITE, 4'd0, -16'sd32768, 16'sh5A5A, 0, 48'sd0, 1'b0, 1'b0);
      table_row(1, ACTION_EVAL, 4'd15, 16'sh7FFF, 16'sh7FFF, 1, -48'sd8388608, 1'b0, 1'b0);
      table_row(1, ACTION_WRITE, 4'd0, 16'sh7FFF, -16'sd1, 0, 48'sd0, 1'b0, 1'b0);
      table_row(1, ACTION_EVAL, 4'd3, -16'sd1, -16'sd32768, 1, 48'sd8388352, 1'b0, 1'b0);
      for (int i = 1; i < MAX_TERMS; i++)
         table_row(16, ACTION_WRITE, 4'(i), 16'sh7FFF, 16'shA5A5, 0, 48'sd0, 1'b0, 1'b0);
      table_row(16, ACTION_EVAL, 4'd0, 16'sh0000, 16'sh7FFF, 1, VAL_MAX, 1'b1, 1'b0);
      table_row(16, ACTION_EVAL, 4'd0, 16'sh0000, -16'sd32768, 0, 48'sd0, 1'b0, 1'b0);
      table_row(31, ACTION_EVAL, 4'd0, 16'sh0000, 16'sh0100, 0, 48'sd0, 1'b0, 1'b0);
      table_row(17, ACTION_EVAL, 4'd0, 16'sh0000, 16'sh0000, 1, 48'sd8388352, 1'b0, 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].terms != applied_terms) set_terms(directed_rows[i].terms);
         send_item(directed_rows[i].action, directed_rows[i].index, directed_rows[i].coef,
                   directed_rows[i].x, directed_rows[i].known, directed_rows[i].want);
      end

      // Every coefficient has been written above, so any term count is safe from here on.
      for (int p = 0; p < PHASES; p++) begin
         n = (p < 7) ? phase_terms[p] : $urandom_range(0, 31);
         set_terms(n);
         repeat (PHASE_BEATS) begin
            action = ($urandom_range(0, 99) < 40) ? ACTION_EVAL : ACTION_WRITE;
            case ($urandom_range(0, 7))
               0:       coef = 16'sh7FFF;
               1:       coef = -16'sd32768;
               default: coef = coef_type'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0, 1:    x = x_type'($urandom);
               2:       x = x_type'($urandom_range(0, 767)) - 16'sd384;
               default: x = x_type'(int'($urandom_range(224, 288)) *
                                    ($urandom_range(0, 1) ? 1 : -1));
            endcase
            send_item(action, 4'($urandom_range(0, 15)), coef, x, 0, none);
         end
      end

      req_tvalid <= 1'b0;
      while (expected_polys.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d coefficient writes and checked %0d evaluations over %0d term settings.",
               writes_sent, evals_checked, settings_made);
      $display("Saturated results: %0d, empty-polynomial results: %0d, mismatches: %0d.",
               sat_seen, empty_seen, errors);
      if (errors == 0 && expected_polys.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
